>>> hdl/rpyrm_pkg.sv
// Shared types, constants and fixed-point helpers for the roll/pitch/yaw
// to rotation matrix pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rpyrm_pkg;

	localparam int ANGLE_W  = 16;
	localparam int MATRIX_W = 16;
	localparam int POS_W    = 32;

	// Q3.30 working values with headroom for the unfolded angle
	localparam int VAL_W = 34;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t Q_ONE     = val_t'(64'd1073741824);
	localparam val_t Q_PI      = val_t'(64'd3373259426);
	localparam val_t Q_HALF_PI = val_t'(64'd1686629713);

	localparam int ANGLE_SH = 33 - ANGLE_W;

	// Horner divisors k*(k-1), outermost term first
	localparam int SIN_STEPS = 6;
	localparam int COS_STEPS = 7;
	localparam int unsigned SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
	localparam int unsigned COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

	// Reciprocal divide: dividend below 2^32, divisor below 2^8
	localparam int DIV_SH = 40;
	localparam int DIV_MW = DIV_SH + 1;
	localparam int DIV_PW = 32 + DIV_MW;

	localparam int TRIG_LAT = 2 * COS_STEPS + 3;
	localparam int MAT_LAT  = 3;
	localparam int PIPE_LAT = TRIG_LAT + MAT_LAT;

	localparam int ENTRY_SH = 32 - MATRIX_W;
	localparam int ENTRY_LIM = 1 << (MATRIX_W - 2);

	localparam int IN_W  = 3 * POS_W + 3 * ANGLE_W;
	localparam int IN_DW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 9 * MATRIX_W + 3 * POS_W;
	localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

	typedef logic [MATRIX_W-1:0] entry_t;
	typedef logic [POS_W-1:0] pos_t;

	// Q30 product, magnitude rounded half away from zero
	function automatic val_t fx_mul(val_t a, val_t b);
		logic neg;
		logic [2*VAL_W-1:0] ua;
		logic [2*VAL_W-1:0] ub;
		logic [2*VAL_W-1:0] p;
		logic [VAL_W-1:0] r;
		neg = a[VAL_W-1] ^ b[VAL_W-1];
		ua = (2*VAL_W)'(a[VAL_W-1] ? unsigned'(-a) : unsigned'(a));
		ub = (2*VAL_W)'(b[VAL_W-1] ? unsigned'(-b) : unsigned'(b));
		p = ua * ub + ((2*VAL_W)'(1) << 29);
		r = p[VAL_W+29:30];
		return neg ? -val_t'(r) : val_t'(r);
	endfunction

	// Q30 to output format, rounded half away from zero, saturated to +-1
	function automatic entry_t to_entry(val_t v);
		logic neg;
		logic [VAL_W-1:0] m;
		val_t r;
		neg = v[VAL_W-1];
		m = neg ? unsigned'(-v) : unsigned'(v);
		m = (m + (VAL_W'(1) << (ENTRY_SH - 1))) >> ENTRY_SH;
		if (m > VAL_W'(ENTRY_LIM))
			m = VAL_W'(ENTRY_LIM);
		r = neg ? -val_t'(m) : val_t'(m);
		return r[MATRIX_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/rpy_pose_to_rotation_matrix.sv
// Pose to 3x4 homogeneous transform, R = Rz(yaw) Ry(pitch) Rx(roll).
// Top level; uses rpyrm_pkg and rpyrm_trig.
//
// Input stream s_axis: one pose word per handshake (position Q16.16, angles
// Q3.13 radians). Output stream m_axis: nine Q1.14 rotation entries, row
// major, then the position copied through unchanged.
// Each input handshake passes through the sine/cosine pipeline (fold, square,
// seven two-stage Horner steps, sign fix) and then the matrix stages:
// products, sums and rounding.
// Throughput is one word per cycle when not stalled; the pipeline advances
// on a single enable, so the per-angle trig pipelines run in lockstep.
// When the receiver stalls with a word waiting, the pipeline freezes and
// s_axis_tready drops in the same cycle; no word is lost or repeated.
// Reset clears the valid bits only; no word is presented after reset until
// one has gone through.
`timescale 1ns / 1ps
`default_nettype none
module rpy_pose_to_rotation_matrix (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle
	input  wire [rpyrm_pkg::IN_DW-1:0]       s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz
	output logic [rpyrm_pkg::OUT_DW-1:0]     m_axis_tdata
);
	import rpyrm_pkg::*;

	logic en;
	logic [PIPE_LAT-1:0] vld_s;
	pos_t pos_s [PIPE_LAT][3];
	logic [ANGLE_W-1:0] ang [3];
	val_t sn [3];
	val_t cs [3];

	// matrix stage 1: first products
	val_t cysp_m1, sysp_m1, e00_m1, e10_m1, e21_m1, e22_m1;
	val_t sycr_m1, sysr_m1, cycr_m1, cysr_m1, sr_m1, cr_m1, sp_m1;
	// matrix stage 2: full entries in Q30
	val_t e_m2 [9];
	// matrix stage 3: output register
	entry_t e_m3 [9];

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	for (genvar i = 0; i < 3; i++) begin : g_trig
		assign ang[i] = s_axis_tdata[3*POS_W + i*ANGLE_W +: ANGLE_W];
		rpyrm_trig u_trig (
			.clk   (clk),
			.en    (en),
			.angle (ang[i]),
			.sin_o (sn[i]),
			.cos_o (cs[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pos_s[0][k] <= s_axis_tdata[k*POS_W +: POS_W];
				for (int n = 1; n < PIPE_LAT; n++)
					pos_s[n][k] <= pos_s[n-1][k];
			end

			// index 0 roll, 1 pitch, 2 yaw
			cysp_m1 <= fx_mul(cs[2], sn[1]);
			sysp_m1 <= fx_mul(sn[2], sn[1]);
			e00_m1 <= fx_mul(cs[2], cs[1]);
			e10_m1 <= fx_mul(sn[2], cs[1]);
			e21_m1 <= fx_mul(cs[1], sn[0]);
			e22_m1 <= fx_mul(cs[1], cs[0]);
			sycr_m1 <= fx_mul(sn[2], cs[0]);
			sysr_m1 <= fx_mul(sn[2], sn[0]);
			cycr_m1 <= fx_mul(cs[2], cs[0]);
			cysr_m1 <= fx_mul(cs[2], sn[0]);
			sr_m1 <= sn[0];
			cr_m1 <= cs[0];
			sp_m1 <= sn[1];

			e_m2[0] <= e00_m1;
			e_m2[1] <= fx_mul(cysp_m1, sr_m1) - sycr_m1;
			e_m2[2] <= fx_mul(cysp_m1, cr_m1) + sysr_m1;
			e_m2[3] <= e10_m1;
			e_m2[4] <= fx_mul(sysp_m1, sr_m1) + cycr_m1;
			e_m2[5] <= fx_mul(sysp_m1, cr_m1) - cysr_m1;
			e_m2[6] <= -sp_m1;
			e_m2[7] <= e21_m1;
			e_m2[8] <= e22_m1;

			for (int k = 0; k < 9; k++)
				e_m3[k] <= to_entry(e_m2[k]);
		end
	end

	assign m_axis_tvalid = vld_s[PIPE_LAT-1];

	always_comb begin
		m_axis_tdata = '0;
		for (int k = 0; k < 9; k++)
			m_axis_tdata[k*MATRIX_W +: MATRIX_W] = e_m3[k];
		for (int k = 0; k < 3; k++)
			m_axis_tdata[9*MATRIX_W + k*POS_W +: POS_W] = pos_s[PIPE_LAT-1][k];
	end

	// checked entries m00 and m22 stay inside +-1 after rounding and saturation
	a_m00_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(e_m3[0]) <= $signed(MATRIX_W'(ENTRY_LIM)) &&
			$signed(e_m3[0]) >= -$signed(MATRIX_W'(ENTRY_LIM))))
		else $error("m00 outside +-1");

	a_m22_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(e_m3[8]) <= $signed(MATRIX_W'(ENTRY_LIM)) &&
			$signed(e_m3[8]) >= -$signed(MATRIX_W'(ENTRY_LIM))))
		else $error("m22 outside +-1");

	// a stalled pipeline keeps its valid bits in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved during stall");

endmodule
`default_nettype wire

>>> hdl/rpyrm_trig.sv
// Pipelined fixed-point sine and cosine: quadrant fold, then one Horner
// term per two stages for both series in parallel. Uses rpyrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpyrm_trig (
	input  wire                              clk,
	input  wire                              en,
	input  wire [rpyrm_pkg::ANGLE_W-1:0]     angle,
	output rpyrm_pkg::val_t                  sin_o,
	output rpyrm_pkg::val_t                  cos_o
);
	import rpyrm_pkg::*;

	val_t a_ext;
	val_t a_s1, a_s2, x2_s2;
	logic flip_s1, flip_s2;

	// step stages: _sa holds the products, _sb the updated series terms
	val_t pc_sa [COS_STEPS];
	val_t ps_sa [COS_STEPS];
	val_t x2_sa [COS_STEPS];
	val_t a_sa  [COS_STEPS];
	logic flip_sa [COS_STEPS];
	val_t c_sb  [COS_STEPS];
	val_t s_sb  [COS_STEPS];
	val_t x2_sb [COS_STEPS];
	val_t a_sb  [COS_STEPS];
	logic flip_sb [COS_STEPS];

	assign a_ext = val_t'($signed(angle)) <<< ANGLE_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			if (a_ext > Q_HALF_PI) begin
				a_s1 <= a_ext - Q_PI;
				flip_s1 <= 1'b1;
			end else if (a_ext < -Q_HALF_PI) begin
				a_s1 <= a_ext + Q_PI;
				flip_s1 <= 1'b1;
			end else begin
				a_s1 <= a_ext;
				flip_s1 <= 1'b0;
			end
			x2_s2 <= fx_mul(a_s1, a_s1);
			a_s2 <= a_s1;
			flip_s2 <= flip_s1;
		end
	end

	for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
		localparam logic [DIV_MW-1:0] C_M =
			DIV_MW'(((64'd1 << DIV_SH) + 64'(COS_DIV[j]) - 64'd1) / 64'(COS_DIV[j]));
		val_t c_in, s_in, x2_in, a_in;
		logic flip_in;
		logic [DIV_PW-1:0] qc_p;
		val_t s_next;

		if (j == 0) begin : g_first
			assign c_in = Q_ONE;
			assign s_in = Q_ONE;
			assign x2_in = x2_s2;
			assign a_in = a_s2;
			assign flip_in = flip_s2;
		end else begin : g_next
			assign c_in = c_sb[j-1];
			assign s_in = s_sb[j-1];
			assign x2_in = x2_sb[j-1];
			assign a_in = a_sb[j-1];
			assign flip_in = flip_sb[j-1];
		end

		assign qc_p = DIV_PW'(pc_sa[j][31:0]) * DIV_PW'(C_M);

		if (j < SIN_STEPS) begin : g_sin_term
			localparam logic [DIV_MW-1:0] S_M =
				DIV_MW'(((64'd1 << DIV_SH) + 64'(SIN_DIV[j]) - 64'd1) / 64'(SIN_DIV[j]));
			logic [DIV_PW-1:0] qs_p;
			assign qs_p = DIV_PW'(ps_sa[j][31:0]) * DIV_PW'(S_M);
			assign s_next = Q_ONE - val_t'(qs_p[DIV_PW-1:DIV_SH]);
		end else begin : g_sin_last
			assign s_next = ps_sa[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pc_sa[j] <= fx_mul(x2_in, c_in);
				ps_sa[j] <= (j < SIN_STEPS) ? fx_mul(x2_in, s_in) : fx_mul(a_in, s_in);
				x2_sa[j] <= x2_in;
				a_sa[j] <= a_in;
				flip_sa[j] <= flip_in;
				c_sb[j] <= Q_ONE - val_t'(qc_p[DIV_PW-1:DIV_SH]);
				s_sb[j] <= s_next;
				x2_sb[j] <= x2_sa[j];
				a_sb[j] <= a_sa[j];
				flip_sb[j] <= flip_sa[j];
			end
		end
	end

	// undo the fold
	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= flip_sb[COS_STEPS-1] ? -s_sb[COS_STEPS-1] : s_sb[COS_STEPS-1];
			cos_o <= flip_sb[COS_STEPS-1] ? -c_sb[COS_STEPS-1] : c_sb[COS_STEPS-1];
		end
	end

endmodule
`default_nettype wire
